### src/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");
// Checks that a signal stays stable in the cycle after the condition holds.
`define ASSERT_HOLD(label, clk, rst_n, pre, sig) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> $stable(sig)) \
		else $error("signal changed");
`endif

### src/gstb_pkg.sv
`default_nettype none
package gstb_pkg;
	localparam int MaxNodes = 64;
	localparam int FreqBits = 16;
	localparam int IdxW = $clog2(MaxNodes);
	localparam int CntW = IdxW + 1;
	localparam logic [6:0] NoneIdx = 7'(MaxNodes);
	localparam logic [15:0] TolReset = 16'd655;
	localparam logic [15:0] TolZeroSub = 16'd7;

	typedef logic [IdxW-1:0] idx_t;
	typedef logic [CntW-1:0] cnt_t;
	typedef logic [FreqBits-1:0] freq_t;
	typedef logic [FreqBits:0] mag_t;
	typedef logic signed [FreqBits+1:0] err_t;

	localparam cnt_t CntOne = cnt_t'(1);

	// Per node data, written when the node joins the tree.
	typedef struct packed {
		idx_t        parent;
		logic [6:0]  layer;
		logic [63:0] path;
	} node_t;

	// Children of a node, written when the node takes its pair.
	typedef struct packed {
		idx_t left;
		idx_t right;
	} kids_t;
endpackage
`default_nettype wire

### src/gstb_ram.sv
`default_nettype none
module gstb_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### src/greedy_sum_tree_build_bfs.sv
// Greedy sum-tree builder. Frequencies stream in one per transfer while
// loading; the transfer with tlast runs a breadth-first build on a sequencer
// around a single adder/comparator that reads the frequency RAM. Taking a
// parent from the queue runs through the pop, pop-data, parent-read and
// parent-load states, each unattached pair it examines through the next-j,
// read-j and compare states, and each skipped candidate only through the
// next-i or next-j state. The N node results then leave one per transfer, each
// through the read, load and output states. The input is not ready from the
// last transfer until the final result has been taken. The tolerance register
// must be written only while the block is idle; a tolerance of zero acts as 7.
`default_nettype none
`include "assert_macros.svh"
module greedy_sum_tree_build_bfs (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // freq
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// node_index, in_tree, parent_index, left_index, right_index, depth, path_id, pad
	output logic [103:0]     m_axis_tdata,
	output logic             m_axis_tlast   // final_res
);
	localparam logic [3:0] StLoad = 4'd0, StInit = 4'd1, StPop = 4'd2, StPopD = 4'd3,
		StRdP = 4'd4, StGetP = 4'd5, StNextI = 4'd6, StRdI = 4'd7, StNextJ = 4'd8,
		StRdJ = 4'd9, StCmp = 4'd10, StAttL = 4'd11, StAttR = 4'd12, StOutRd = 4'd13,
		StOutLd = 4'd14, StOut = 4'd15;

	logic [3:0] state_q;
	logic [15:0] tol_q;
	gstb_pkg::cnt_t n_q, head_q, tail_q, i_q, j_q, k_q;
	gstb_pkg::idx_t p_q, lc_q, rc_q;
	logic found_q;
	gstb_pkg::mag_t bound_q;
	gstb_pkg::freq_t fp_q, fi_q;
	logic [6:0] pl_q;
	logic [63:0] pp_q;
	logic [gstb_pkg::MaxNodes-1:0] att_q, ch_q;

	logic fwe;
	gstb_pkg::idx_t fwaddr, fraddr;
	gstb_pkg::freq_t frdata;

	logic qwe;
	gstb_pkg::idx_t qwaddr, qwdata, qrdata;

	logic nwe;
	gstb_pkg::idx_t nwaddr, nraddr;
	gstb_pkg::node_t nwdata, nrdata;

	logic kwe;
	gstb_pkg::kids_t kwdata, krdata;

	gstb_ram #(.Width(gstb_pkg::FreqBits), .Depth(gstb_pkg::MaxNodes)) u_freq (
		.clk(clk), .we(fwe), .waddr(fwaddr), .wdata(s_axis_tdata[gstb_pkg::FreqBits-1:0]),
		.raddr(fraddr), .rdata(frdata)
	);

	gstb_ram #(.Width(gstb_pkg::IdxW), .Depth(gstb_pkg::MaxNodes)) u_queue (
		.clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata),
		.raddr(head_q[gstb_pkg::IdxW-1:0]), .rdata(qrdata)
	);

	gstb_ram #(.Width($bits(gstb_pkg::node_t)), .Depth(gstb_pkg::MaxNodes)) u_node (
		.clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
		.raddr(nraddr), .rdata(nrdata)
	);

	gstb_ram #(.Width($bits(gstb_pkg::kids_t)), .Depth(gstb_pkg::MaxNodes)) u_kids (
		.clk(clk), .we(kwe), .waddr(p_q), .wdata(kwdata),
		.raddr(k_q[gstb_pkg::IdxW-1:0]), .rdata(krdata)
	);

	logic in_acc;
	assign s_axis_tready = (state_q == StLoad);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign fwe = in_acc && (n_q < gstb_pkg::cnt_t'(gstb_pkg::MaxNodes));
	assign fwaddr = n_q[gstb_pkg::IdxW-1:0];

	always_comb begin
		unique case (state_q)
			StRdP:   fraddr = p_q;
			StRdI:   fraddr = i_q[gstb_pkg::IdxW-1:0];
			default: fraddr = j_q[gstb_pkg::IdxW-1:0];
		endcase
	end

	// The queue holds the root at build start, then each attached child in turn.
	assign qwe = (state_q == StInit) || (((state_q == StAttL) || (state_q == StAttR))
		&& (tail_q < gstb_pkg::cnt_t'(gstb_pkg::MaxNodes)));
	assign qwaddr = (state_q == StInit) ? '0 : tail_q[gstb_pkg::IdxW-1:0];
	assign qwdata = (state_q == StAttL) ? lc_q : ((state_q == StAttR) ? rc_q : '0);

	assign nwe = (state_q == StInit) || (state_q == StAttL) || (state_q == StAttR);
	assign nwaddr = (state_q == StAttL) ? lc_q : ((state_q == StAttR) ? rc_q : '0);
	assign nraddr = (state_q == StRdP) ? p_q : k_q[gstb_pkg::IdxW-1:0];

	always_comb begin
		nwdata.parent = p_q;
		nwdata.layer = pl_q + 7'd1;
		nwdata.path = {pp_q[62:0], (state_q == StAttR)};
		if (state_q == StInit) begin
			nwdata.parent = '0;
			nwdata.layer = 7'd1;
			nwdata.path = 64'd1;
		end
	end

	assign kwe = (state_q == StAttL);
	assign kwdata = '{left: lc_q, right: rc_q};

	// Error of the current pair, one shared adder and magnitude compare.
	gstb_pkg::err_t err;
	gstb_pkg::mag_t abs_err;
	assign err = gstb_pkg::err_t'({2'b00, fi_q}) + gstb_pkg::err_t'({2'b00, frdata})
		- gstb_pkg::err_t'({2'b00, fp_q});
	assign abs_err = err[gstb_pkg::FreqBits+1] ? gstb_pkg::mag_t'(-err)
		: gstb_pkg::mag_t'(err);

	logic i_att, j_att;
	assign i_att = att_q[i_q[gstb_pkg::IdxW-1:0]];
	assign j_att = att_q[j_q[gstb_pkg::IdxW-1:0]];

	// Store entries count only where the flags say the current build wrote them.
	logic k_att, k_kids, kin;
	logic [6:0] par_o, left_o, right_o;
	assign k_att = att_q[k_q[gstb_pkg::IdxW-1:0]];
	assign k_kids = ch_q[k_q[gstb_pkg::IdxW-1:0]];
	assign kin = (k_q == '0) || k_att;
	assign par_o = k_att ? {1'b0, nrdata.parent} : gstb_pkg::NoneIdx;
	assign left_o = k_kids ? {1'b0, krdata.left} : gstb_pkg::NoneIdx;
	assign right_o = k_kids ? {1'b0, krdata.right} : gstb_pkg::NoneIdx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= gstb_pkg::TolReset;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StLoad;
			n_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			p_q <= '0;
			lc_q <= '0;
			rc_q <= '0;
			found_q <= 1'b0;
			bound_q <= '0;
			fp_q <= '0;
			fi_q <= '0;
			pl_q <= '0;
			pp_q <= '0;
			att_q <= '0;
			ch_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
		end else begin
			unique case (state_q)
				StLoad: if (in_acc) begin
					if (fwe) n_q <= n_q + gstb_pkg::CntOne;
					if (s_axis_tlast) state_q <= StInit;
				end
				StInit: begin
					att_q <= '0;
					ch_q <= '0;
					head_q <= '0;
					tail_q <= gstb_pkg::CntOne;
					k_q <= '0;
					state_q <= StPop;
				end
				StPop: begin
					if (head_q < tail_q) begin
						head_q <= head_q + gstb_pkg::CntOne;
						state_q <= StPopD;
					end else begin
						state_q <= StOutRd;
					end
				end
				StPopD: begin
					p_q <= qrdata;
					i_q <= {1'b0, qrdata} + gstb_pkg::CntOne;
					found_q <= 1'b0;
					bound_q <= gstb_pkg::mag_t'((tol_q == '0) ? gstb_pkg::TolZeroSub : tol_q);
					state_q <= StRdP;
				end
				StRdP: state_q <= StGetP;
				StGetP: begin
					fp_q <= frdata;
					pl_q <= nrdata.layer;
					pp_q <= nrdata.path;
					state_q <= StNextI;
				end
				StNextI: begin
					if (i_q + gstb_pkg::CntOne >= n_q) begin
						state_q <= found_q ? StAttL : StPop;
					end else if (i_att) begin
						i_q <= i_q + gstb_pkg::CntOne;
					end else begin
						j_q <= i_q + gstb_pkg::CntOne;
						state_q <= StRdI;
					end
				end
				StRdI: state_q <= StNextJ;
				StNextJ: begin
					if (j_q == i_q + gstb_pkg::CntOne) fi_q <= frdata;
					if (j_q >= n_q) begin
						i_q <= i_q + gstb_pkg::CntOne;
						state_q <= StNextI;
					end else if (j_att) begin
						j_q <= j_q + gstb_pkg::CntOne;
					end else begin
						state_q <= StRdJ;
					end
				end
				StRdJ: state_q <= StCmp;
				StCmp: begin
					if (abs_err < bound_q) begin
						lc_q <= i_q[gstb_pkg::IdxW-1:0];
						rc_q <= j_q[gstb_pkg::IdxW-1:0];
						bound_q <= abs_err;
						found_q <= 1'b1;
					end
					if (err[gstb_pkg::FreqBits+1]) begin
						i_q <= i_q + gstb_pkg::CntOne;
						state_q <= StNextI;
					end else begin
						j_q <= j_q + gstb_pkg::CntOne;
						state_q <= StNextJ;
					end
				end
				StAttL: begin
					att_q[lc_q] <= 1'b1;
					ch_q[p_q] <= 1'b1;
					if (tail_q < gstb_pkg::cnt_t'(gstb_pkg::MaxNodes))
						tail_q <= tail_q + gstb_pkg::CntOne;
					state_q <= StAttR;
				end
				StAttR: begin
					att_q[rc_q] <= 1'b1;
					if (tail_q < gstb_pkg::cnt_t'(gstb_pkg::MaxNodes))
						tail_q <= tail_q + gstb_pkg::CntOne;
					state_q <= StPop;
				end
				StOutRd: begin
					if (k_q >= n_q) begin
						n_q <= '0;
						head_q <= '0;
						tail_q <= '0;
						state_q <= StLoad;
					end else begin
						state_q <= StOutLd;
					end
				end
				StOutLd: begin
					m_axis_tdata <= {5'b0, (kin ? nrdata.path : 64'd0),
						(kin ? nrdata.layer : 7'd0), right_o, left_o, par_o, kin,
						k_q[gstb_pkg::IdxW-1:0]};
					m_axis_tlast <= (k_q + gstb_pkg::CntOne == n_q);
					m_axis_tvalid <= 1'b1;
					state_q <= StOut;
				end
				StOut: if (m_axis_tready) begin
					m_axis_tvalid <= 1'b0;
					k_q <= k_q + gstb_pkg::CntOne;
					state_q <= StOutRd;
				end
			endcase
		end
	end

	`ASSERT_IMPL(a_ready_idle, clk, arst_n, !(s_axis_tready && m_axis_tvalid))
	`ASSERT_IMPL(a_count_cap, clk, arst_n, n_q <= gstb_pkg::cnt_t'(gstb_pkg::MaxNodes))
	`ASSERT_HOLD(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tdata)
endmodule
`default_nettype wire

### bench/greedy_sum_tree_build_bfs_tb.sv
`default_nettype none
module greedy_sum_tree_build_bfs_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0]  idx;
		logic        in_tree;
		logic [6:0]  parent;
		logic [6:0]  left;
		logic [6:0]  right;
		logic [6:0]  depth;
		logic [63:0] path;
		logic        fin;
	} node_res_t;

	typedef struct packed {
		logic [15:0] freq;
		logic        last;
	} cand_t;

	// Directed stimulus: an optional tolerance write before the item, and an
	// optional typed-in result for the root-only run.
	typedef struct packed {
		logic        wr_tol;
		logic [15:0] tol;
		logic [15:0] freq;
		logic        last;
		logic        root_only;
	} row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [15:0]  s_axis_tdata = '0;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         m_axis_tlast;

	greedy_sum_tree_build_bfs u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow state of the tree builder.
	logic [15:0] tol_shadow = gstb_pkg::TolReset;
	logic [15:0] freq_mem [gstb_pkg::MaxNodes];
	int          loaded = 0;
	logic        root_pending = 1'b0;

	node_res_t   node_exp_q [$];
	cand_t       feed_q [$];
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int          hold_cnt = 0;
	int          mismatches = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          trees_built = 0;

	function automatic void build_tree(int n);
		int par [gstb_pkg::MaxNodes];
		int lft [gstb_pkg::MaxNodes];
		int rgt [gstb_pkg::MaxNodes];
		int lay [gstb_pkg::MaxNodes];
		logic [63:0] pth [gstb_pkg::MaxNodes];
		int bfs_q [gstb_pkg::MaxNodes];
		int head, tail, p, lc, rc, bound, err, tol, aerr;
		node_res_t r;
		for (int k = 0; k < gstb_pkg::MaxNodes; k++) begin
			par[k] = gstb_pkg::MaxNodes;
			lft[k] = gstb_pkg::MaxNodes;
			rgt[k] = gstb_pkg::MaxNodes;
			lay[k] = 0;
			pth[k] = '0;
		end
		tol = (tol_shadow == 16'd0) ? int'(gstb_pkg::TolZeroSub) : int'(tol_shadow);
		lay[0] = 1;
		pth[0] = 64'd1;
		bfs_q[0] = 0;
		head = 0;
		tail = 1;
		while (head < tail && head < gstb_pkg::MaxNodes) begin
			p = bfs_q[head];
			head++;
			lc = gstb_pkg::MaxNodes;
			rc = gstb_pkg::MaxNodes;
			bound = tol;
			for (int i = p + 1; i + 1 < n; i++) begin
				if (par[i] != gstb_pkg::MaxNodes)
					continue;
				for (int j = i + 1; j < n; j++) begin
					if (par[j] != gstb_pkg::MaxNodes)
						continue;
					err = int'(freq_mem[i]) + int'(freq_mem[j]) - int'(freq_mem[p]);
					aerr = (err < 0) ? -err : err;
					if (aerr < bound) begin
						lc = i;
						rc = j;
						bound = aerr;
					end
					if (err < 0)
						break;
				end
			end
			if (lc != gstb_pkg::MaxNodes) begin
				lft[p] = lc;
				rgt[p] = rc;
				par[lc] = p;
				par[rc] = p;
				lay[lc] = (lay[p] + 1) & 7'h7f;
				lay[rc] = (lay[p] + 1) & 7'h7f;
				pth[lc] = pth[p] << 1;
				pth[rc] = (pth[p] << 1) | 64'd1;
				if (tail < gstb_pkg::MaxNodes) begin
					bfs_q[tail] = lc;
					tail++;
				end
				if (tail < gstb_pkg::MaxNodes) begin
					bfs_q[tail] = rc;
					tail++;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			r.idx = 6'(k);
			r.in_tree = (k == 0) || (par[k] != gstb_pkg::MaxNodes);
			r.parent = 7'(par[k]);
			r.left = 7'(lft[k]);
			r.right = 7'(rgt[k]);
			r.depth = r.in_tree ? 7'(lay[k]) : 7'd0;
			r.path = r.in_tree ? pth[k] : 64'd0;
			r.fin = (k + 1 == n);
			node_exp_q = {node_exp_q, r};
		end
	endfunction

	function automatic void absorb(logic [15:0] f, logic lst);
		node_res_t r;
		if (loaded < gstb_pkg::MaxNodes) begin
			freq_mem[loaded] = f;
			loaded++;
		end
		if (lst) begin
			trees_built++;
			if (root_pending) begin
				// A lone node is the root with no children.
				r = '{idx: 6'd0, in_tree: 1'b1, parent: gstb_pkg::NoneIdx,
					left: gstb_pkg::NoneIdx, right: gstb_pkg::NoneIdx, depth: 7'd1,
					path: 64'd1, fin: 1'b1};
				node_exp_q = {node_exp_q, r};
				root_pending = 1'b0;
			end else begin
				build_tree(loaded);
			end
			loaded = 0;
		end
	endfunction

	// Sender: hold the offered item until its transfer, then maybe idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb(s_axis_tdata, s_axis_tlast);
				items_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_q.size() != 0 && (quiet || $urandom_range(99) >= 19)) begin
					cand_t c;
					c = feed_q[0];
					feed_q.delete(0);
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= c.freq;
					s_axis_tlast <= c.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				node_res_t got, want;
				got.idx = m_axis_tdata[5:0];
				got.in_tree = m_axis_tdata[6];
				got.parent = m_axis_tdata[13:7];
				got.left = m_axis_tdata[20:14];
				got.right = m_axis_tdata[27:21];
				got.depth = m_axis_tdata[34:28];
				got.path = m_axis_tdata[98:35];
				got.fin = m_axis_tlast;
				results_seen++;
				if (node_exp_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: node %0d parent %0d", got.idx,
							got.parent);
				end else begin
					want = node_exp_q[0];
					node_exp_q.delete(0);
					if (got.idx != want.idx || got.in_tree != want.in_tree ||
						got.parent != want.parent || got.left != want.left ||
						got.right != want.right || got.depth != want.depth ||
						got.path != want.path || got.fin != want.fin) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("node result differs");
							$display("  want %0d in %0d p %0d l %0d r %0d d %0d %h f %0d",
								want.idx, want.in_tree, want.parent, want.left,
								want.right, want.depth, want.path, want.fin);
							$display("  got  %0d in %0d p %0d l %0d r %0d d %0d %h f %0d",
								got.idx, got.in_tree, got.parent, got.left,
								got.right, got.depth, got.path, got.fin);
						end
					end
				end
			end
			if (hold_req) begin
				hold_req <= 1'b0;
				hold_cnt <= 400;
				m_axis_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || $urandom_range(99) >= 19;
			end
		end
	end

	task automatic drain();
		while (feed_q.size() != 0 || s_axis_tvalid || node_exp_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_tol(logic [15:0] v);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_shadow = v;
	endtask

	// Sum tree grown by splitting nodes, with small errors, sorted descending.
	task automatic queue_tree_run(int splits, int noise);
		int vals [$];
		int pick, a, b;
		vals = {vals, int'($urandom_range(65535, 1000))};
		for (int s = 0; s < splits; s++) begin
			pick = $urandom_range(vals.size() - 1);
			a = $urandom_range(vals[pick]);
			b = vals[pick] - a + $urandom_range(2 * noise) - noise;
			if (b < 0) b = 0;
			if (b > 65535) b = 65535;
			vals = {vals, a, b};
		end
		vals.rsort();
		foreach (vals[k])
			feed_q = {feed_q, cand_t'{freq: 16'(vals[k]), last: k == vals.size() - 1}};
	endtask

	task automatic queue_noise_run(int n);
		for (int k = 0; k < n; k++)
			feed_q = {feed_q, cand_t'{freq: 16'($urandom), last: k == n - 1}};
	endtask

	row_t rows [] = '{
		'{1'b0, 16'd0, 16'hffff, 1'b1, 1'b1},
		'{1'b0, 16'd0, 16'd40000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd20000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd20000, 1'b1, 1'b0},
		'{1'b0, 16'd0, 16'd100, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd60000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd50, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd60, 1'b1, 1'b0},
		'{1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd0, 1'b1, 1'b0},
		'{1'b1, 16'd0, 16'd1000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd500, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd503, 1'b1, 1'b0},
		'{1'b0, 16'd0, 16'd1000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd500, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd508, 1'b1, 1'b0},
		'{1'b1, 16'hffff, 16'hffff, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'hffff, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd0, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd1, 1'b1, 1'b0},
		'{1'b1, 16'd1, 16'd30000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd15000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd15000, 1'b0, 1'b0},
		'{1'b0, 16'd0, 16'd7500, 1'b1, 1'b0}
	};

	initial begin
		int run;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (rows[k]) begin
			if (rows[k].wr_tol)
				write_tol(rows[k].tol);
			if (rows[k].root_only) begin
				drain();
				root_pending = 1'b1;
			end
			feed_q = {feed_q, cand_t'{freq: rows[k].freq, last: rows[k].last}};
		end
		drain();

		// The receiver stalls long while two runs are offered back to back.
		write_tol(16'd655);
		hold_req = 1'b1;
		queue_tree_run(2, 200);
		queue_tree_run(1, 0);
		drain();

		// Overflow run: 66 items into 64 places, the last mark on a dropped item.
		// Both sides stay busy throughout this run.
		write_tol(16'd2000);
		quiet = 1'b1;
		queue_tree_run(20, 300);
		while (feed_q.size() < 66)
			feed_q = {feed_q, cand_t'{freq: 16'($urandom_range(50)), last: 1'b0}};
		feed_q[64].last = 1'b0;
		feed_q[65].last = 1'b1;
		for (int k = 0; k < 64; k++)
			if (feed_q[k].last) feed_q[k].last = 1'b0;
		drain();
		quiet = 1'b0;

		run = 0;
		while (items_sent < 112) begin
			case ($urandom_range(5))
				0: write_tol(16'd1);
				1: write_tol(16'hffff);
				2: write_tol(16'($urandom_range(3000)));
				default: ;
			endcase
			if ($urandom_range(3) == 0)
				queue_noise_run($urandom_range(8, 1));
			else
				queue_tree_run($urandom_range(4), $urandom_range(400));
			drain();
			run++;
		end

		repeat (200) @(posedge clk);
		$display("Built %0d trees from %0d candidates, %0d node results checked,",
			trees_built, items_sent, results_seen);
		$display("tolerance swept across its extremes, with stalls on both sides.");
		if (mismatches == 0 && node_exp_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#400ms;
		$display("Timed out with %0d results outstanding", node_exp_q.size());
		$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/gstb_pkg.sv
src/gstb_ram.sv
src/greedy_sum_tree_build_bfs.sv
bench/greedy_sum_tree_build_bfs_tb.sv
